// ----- rtl/tnt_pkg.sv -----
// tnt_pkg: shared types and constants of the triangle normal and tangent unit
// used by tnt_ctrl, tnt_dp and triangle_normal_tangent_top; no dependencies
`timescale 1ns / 1ps

package tnt_pkg;

	localparam int unsigned POS_W      = 32;
	localparam int unsigned TEX_W      = 20;
	localparam int unsigned RES_W      = 16;
	localparam int unsigned IN_W       = 3 * POS_W + 2 * TEX_W;
	localparam int unsigned OUT_W      = 6 * RES_W;
	localparam int unsigned DEG_W      = 2;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned PROD_OPS   = 14;
	localparam int unsigned SQ_OPS     = 3;
	localparam int unsigned SQRT_STEPS = 31;
	localparam int unsigned DIV_STEPS  = 16;

	typedef enum logic [4:0] {
		MS_DET_A, MS_DET_B,
		MS_N0_A, MS_N0_B, MS_N1_A, MS_N1_B, MS_N2_A, MS_N2_B,
		MS_T0_A, MS_T0_B, MS_T1_A, MS_T1_B, MS_T2_A, MS_T2_B,
		MS_SQ0, MS_SQ1, MS_SQ2
	} mul_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_EDGE, ST_SCALE, ST_MUL, ST_MFLUSH,
		ST_ULOAD, ST_UCHK, ST_UNORM, ST_USQ, ST_USQF,
		ST_SQI, ST_SQS, ST_DVI, ST_DVS, ST_DVW, ST_UNEXT, ST_OUT
	} state_t;

	typedef struct packed {
		logic     hold_wr;
		logic     hold_slot;
		logic     tri_wr;
		logic     edge_en;
		logic     scale_en;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     uload;
		logic     vsel;
		logic     unorm;
		logic     sqrt_init;
		logic     sqrt_step;
		logic     div_init;
		logic     div_step;
		logic     div_wr;
		logic     deg_wr;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic vec_zero;
		logic norm_done;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/tnt_ctrl.sv -----
// tnt_ctrl: sequencer of the triangle normal and tangent unit
// depends on tnt_pkg; drives tnt_dp by command, reads its status
`timescale 1ns / 1ps

module tnt_ctrl
	import tnt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t            state_q, state_nx;
	logic [CNT_W-1:0]  cnt_q, cnt_nx;
	logic [1:0]        corner_q, corner_nx;
	logic              vsel_q, vsel_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			corner_q <= '0;
			vsel_q   <= 1'b0;
		end else begin
			state_q  <= state_nx;
			cnt_q    <= cnt_nx;
			corner_q <= corner_nx;
			vsel_q   <= vsel_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cnt_nx    = cnt_q;
		corner_nx = corner_q;
		vsel_nx   = vsel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (corner_q == 2'd2) begin
						corner_nx = 2'd0;
						state_nx  = ST_EDGE;
					end else begin
						corner_nx = corner_q + 2'd1;
					end
				end
			end
			ST_EDGE: state_nx = ST_SCALE;
			ST_SCALE: begin
				cnt_nx   = '0;
				state_nx = ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == CNT_W'(PROD_OPS - 1)) state_nx = ST_MFLUSH;
				else cnt_nx = cnt_q + 1'b1;
			end
			ST_MFLUSH: begin
				vsel_nx  = 1'b0;
				state_nx = ST_ULOAD;
			end
			ST_ULOAD: state_nx = ST_UCHK;
			ST_UCHK: begin
				if (status.vec_zero) state_nx = ST_UNEXT;
				else state_nx = ST_UNORM;
			end
			ST_UNORM: begin
				if (status.norm_done) begin
					cnt_nx   = '0;
					state_nx = ST_USQ;
				end
			end
			ST_USQ: begin
				if (cnt_q == CNT_W'(SQ_OPS - 1)) state_nx = ST_USQF;
				else cnt_nx = cnt_q + 1'b1;
			end
			ST_USQF: state_nx = ST_SQI;
			ST_SQI: begin
				cnt_nx   = '0;
				state_nx = ST_SQS;
			end
			ST_SQS: begin
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_nx = ST_DVI;
				else cnt_nx = cnt_q + 1'b1;
			end
			ST_DVI: begin
				cnt_nx   = '0;
				state_nx = ST_DVS;
			end
			ST_DVS: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_nx = ST_DVW;
				else cnt_nx = cnt_q + 1'b1;
			end
			ST_DVW: state_nx = ST_UNEXT;
			ST_UNEXT: begin
				if (!vsel_q) begin
					vsel_nx  = 1'b1;
					state_nx = ST_ULOAD;
				end else begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.vsel      = vsel_q;
		cmd.hold_slot = corner_q[0];
		cmd.mul_sel   = MS_DET_A;
		in_ready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (corner_q == 2'd2) cmd.tri_wr = 1'b1;
					else cmd.hold_wr = 1'b1;
				end
			end
			ST_EDGE:  cmd.edge_en = 1'b1;
			ST_SCALE: cmd.scale_en = 1'b1;
			ST_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = mul_sel_t'(cnt_q);
			end
			ST_ULOAD: cmd.uload = 1'b1;
			ST_UCHK:  cmd.deg_wr = status.vec_zero;
			ST_UNORM: cmd.unorm = !status.norm_done;
			ST_USQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = mul_sel_t'(CNT_W'(MS_SQ0) + cnt_q);
			end
			ST_SQI: cmd.sqrt_init = 1'b1;
			ST_SQS: cmd.sqrt_step = 1'b1;
			ST_DVI: cmd.div_init = 1'b1;
			ST_DVS: cmd.div_step = 1'b1;
			ST_DVW: cmd.div_wr = 1'b1;
			ST_OUT: cmd.out_load = status.out_free;
			default: cmd = '0;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) cmd.out_load |-> status.out_free)
		else $error("result loaded over an untaken transfer");
	assert property (@(posedge clk) disable iff (!arst_n) corner_q != 2'd3)
		else $error("corner count out of range");

endmodule

// ----- rtl/tnt_dp.sv -----
// tnt_dp: datapath of the triangle normal and tangent unit
// depends on tnt_pkg; shared multiplier, shift normaliser, sqrt and divide steps
`timescale 1ns / 1ps

module tnt_dp
	import tnt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [IN_W-1:0]  in_data,
	output status_t          status,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data,
	output logic [DEG_W-1:0] out_user
);

	logic signed [POS_W-1:0] pos [3];
	logic signed [TEX_W-1:0] tex [2];

	logic signed [POS_W-1:0] hp_q [2][3];
	logic signed [TEX_W-1:0] huv_q [2][2];
	logic signed [POS_W-1:0] p2_q [3];
	logic signed [TEX_W-1:0] uv2_q [2];

	logic signed [POS_W:0]   e1_q [3];
	logic signed [POS_W:0]   e2_q [3];
	logic signed [TEX_W:0]   du1_q, dv1_q, du2_q, dv2_q;
	logic signed [30:0]      s1_q [3];
	logic signed [30:0]      s2_q [3];
	logic signed [30:0]      s1_nx [3];
	logic signed [30:0]      s2_nx [3];

	logic signed [33:0]      ma, mb;
	logic signed [67:0]      prod_full;
	logic signed [63:0]      prod_s1;
	mul_sel_t                sel_s1;
	logic                    vld_s1;
	logic signed [63:0]      acc_q;
	logic signed [63:0]      diff;
	logic                    det_neg_q;
	logic signed [63:0]      vec_q [2][3];

	logic [62:0]             m_q [3];
	logic                    neg_q [3];
	logic [61:0]             ssum_q;
	logic [61:0]             sq_n_q, sq_res_q, sq_bit_q, sq_t;
	logic [45:0]             num_q [3];
	logic [45:0]             d_q;
	logic [15:0]             q_q [3];
	logic [15:0]             res_q [2][3];
	logic [DEG_W-1:0]        deg_q;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;
	logic [DEG_W-1:0]        out_user_q;

	logic                    big, tiny;
	logic [1:0]              sh;
	logic [2:0]              hi_or;

	always_comb begin
		for (int i = 0; i < 3; i++) pos[i] = in_data[i*POS_W +: POS_W];
		for (int i = 0; i < 2; i++) tex[i] = in_data[3*POS_W + i*TEX_W +: TEX_W];
	end

	// corner hold and edge set-up
	always_ff @(posedge clk) begin
		if (cmd.hold_wr) begin
			for (int i = 0; i < 3; i++) hp_q[cmd.hold_slot][i] <= pos[i];
			for (int i = 0; i < 2; i++) huv_q[cmd.hold_slot][i] <= tex[i];
		end
		if (cmd.tri_wr) begin
			for (int i = 0; i < 3; i++) p2_q[i] <= pos[i];
			for (int i = 0; i < 2; i++) uv2_q[i] <= tex[i];
		end
		if (cmd.edge_en) begin
			for (int i = 0; i < 3; i++) begin
				e1_q[i] <= (POS_W+1)'(hp_q[1][i]) - (POS_W+1)'(hp_q[0][i]);
				e2_q[i] <= (POS_W+1)'(p2_q[i]) - (POS_W+1)'(hp_q[0][i]);
			end
			du1_q <= (TEX_W+1)'(huv_q[1][0]) - (TEX_W+1)'(huv_q[0][0]);
			dv1_q <= (TEX_W+1)'(huv_q[1][1]) - (TEX_W+1)'(huv_q[0][1]);
			du2_q <= (TEX_W+1)'(uv2_q[0]) - (TEX_W+1)'(huv_q[0][0]);
			dv2_q <= (TEX_W+1)'(uv2_q[1]) - (TEX_W+1)'(huv_q[0][1]);
		end
		if (cmd.scale_en) begin
			for (int i = 0; i < 3; i++) begin
				s1_q[i] <= s1_nx[i];
				s2_q[i] <= s2_nx[i];
			end
		end
	end

	// common shift that brings the magnitudes of all edge components of e1 and e2 below 2^30
	always_comb begin
		logic [POS_W:0] mg1 [3];
		logic [POS_W:0] mg2 [3];
		logic [29:0]    sm1, sm2;
		hi_or = '0;
		for (int i = 0; i < 3; i++) begin
			mg1[i] = e1_q[i][POS_W] ? -e1_q[i] : e1_q[i];
			mg2[i] = e2_q[i][POS_W] ? -e2_q[i] : e2_q[i];
			hi_or  = hi_or | mg1[i][32:30] | mg2[i][32:30];
		end
		sh = hi_or[2] ? 2'd3 : hi_or[1] ? 2'd2 : hi_or[0] ? 2'd1 : 2'd0;
		for (int i = 0; i < 3; i++) begin
			sm1 = 30'(mg1[i] >> sh);
			sm2 = 30'(mg2[i] >> sh);
			s1_nx[i] = e1_q[i][POS_W] ? -{1'b0, sm1} : {1'b0, sm1};
			s2_nx[i] = e2_q[i][POS_W] ? -{1'b0, sm2} : {1'b0, sm2};
		end
	end

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mul_sel)
			MS_DET_A: begin ma = 34'(du1_q);   mb = 34'(dv2_q);   end
			MS_DET_B: begin ma = 34'(du2_q);   mb = 34'(dv1_q);   end
			MS_N0_A:  begin ma = 34'(s1_q[1]); mb = 34'(s2_q[2]); end
			MS_N0_B:  begin ma = 34'(s1_q[2]); mb = 34'(s2_q[1]); end
			MS_N1_A:  begin ma = 34'(s1_q[2]); mb = 34'(s2_q[0]); end
			MS_N1_B:  begin ma = 34'(s1_q[0]); mb = 34'(s2_q[2]); end
			MS_N2_A:  begin ma = 34'(s1_q[0]); mb = 34'(s2_q[1]); end
			MS_N2_B:  begin ma = 34'(s1_q[1]); mb = 34'(s2_q[0]); end
			MS_T0_A:  begin ma = 34'(dv2_q);   mb = 34'(e1_q[0]); end
			MS_T0_B:  begin ma = 34'(dv1_q);   mb = 34'(e2_q[0]); end
			MS_T1_A:  begin ma = 34'(dv2_q);   mb = 34'(e1_q[1]); end
			MS_T1_B:  begin ma = 34'(dv1_q);   mb = 34'(e2_q[1]); end
			MS_T2_A:  begin ma = 34'(dv2_q);   mb = 34'(e1_q[2]); end
			MS_T2_B:  begin ma = 34'(dv1_q);   mb = 34'(e2_q[2]); end
			MS_SQ0:   begin ma = {4'b0, m_q[0][29:0]}; mb = {4'b0, m_q[0][29:0]}; end
			MS_SQ1:   begin ma = {4'b0, m_q[1][29:0]}; mb = {4'b0, m_q[1][29:0]}; end
			MS_SQ2:   begin ma = {4'b0, m_q[2][29:0]}; mb = {4'b0, m_q[2][29:0]}; end
			default:  begin ma = '0; mb = '0; end
		endcase
		prod_full = ma * mb;
		diff      = acc_q - prod_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= cmd.mul_en;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_full[63:0];
		sel_s1  <= cmd.mul_sel;
		if (vld_s1) begin
			case (sel_s1)
				MS_DET_B: det_neg_q   <= diff[63];
				MS_N0_B:  vec_q[0][0] <= diff;
				MS_N1_B:  vec_q[0][1] <= diff;
				MS_N2_B:  vec_q[0][2] <= diff;
				MS_T0_B:  vec_q[1][0] <= det_neg_q ? -diff : diff;
				MS_T1_B:  vec_q[1][1] <= det_neg_q ? -diff : diff;
				MS_T2_B:  vec_q[1][2] <= det_neg_q ? -diff : diff;
				MS_SQ1:   acc_q       <= acc_q + prod_s1;
				MS_SQ2:   ssum_q      <= 62'(acc_q + prod_s1);
				default:  acc_q       <= prod_s1;
			endcase
		end
	end

	// magnitude load and one-bit normalising shifts
	always_comb begin
		big  = 1'b0;
		tiny = 1'b1;
		for (int i = 0; i < 3; i++) begin
			big  = big | (m_q[i][62:30] != '0);
			tiny = tiny & (m_q[i][62:29] == '0);
		end
		status.vec_zero  = (m_q[0] == '0) && (m_q[1] == '0) && (m_q[2] == '0);
		status.norm_done = !big && !tiny;
		status.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.uload) begin
			for (int i = 0; i < 3; i++) begin
				m_q[i]   <= vec_q[cmd.vsel][i][63] ? 63'(-vec_q[cmd.vsel][i])
					: vec_q[cmd.vsel][i][62:0];
				neg_q[i] <= vec_q[cmd.vsel][i][63];
			end
		end else if (cmd.unorm) begin
			for (int i = 0; i < 3; i++) m_q[i] <= big ? (m_q[i] >> 1) : (m_q[i] << 1);
		end
	end

	// bit-pair square root, one step a cycle
	always_comb sq_t = sq_res_q + sq_bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			sq_n_q   <= ssum_q;
			sq_res_q <= '0;
			sq_bit_q <= 62'd1 << 60;
		end else if (cmd.sqrt_step) begin
			if (sq_n_q >= sq_t) begin
				sq_n_q   <= sq_n_q - sq_t;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// three restoring dividers sharing one shifted divisor
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			for (int i = 0; i < 3; i++) begin
				num_q[i] <= {1'b0, m_q[i][29:0], 15'b0} + 46'(sq_res_q[30:1]);
				q_q[i]   <= '0;
			end
			d_q <= {sq_res_q[30:0], 15'b0};
		end else if (cmd.div_step) begin
			for (int i = 0; i < 3; i++) begin
				if (num_q[i] >= d_q) begin
					num_q[i] <= num_q[i] - d_q;
					q_q[i]   <= {q_q[i][14:0], 1'b1};
				end else begin
					q_q[i]   <= {q_q[i][14:0], 1'b0};
				end
			end
			d_q <= d_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		logic [15:0] sat;
		if (cmd.div_wr) begin
			for (int i = 0; i < 3; i++) begin
				sat = (q_q[i] > 16'd32767) ? 16'd32767 : q_q[i];
				res_q[cmd.vsel][i] <= neg_q[i] ? (~sat + 16'd1) : sat;
			end
			deg_q[cmd.vsel] <= 1'b0;
		end else if (cmd.deg_wr) begin
			for (int i = 0; i < 3; i++) res_q[cmd.vsel][i] <= '0;
			deg_q[cmd.vsel] <= 1'b1;
		end
		if (cmd.out_load) begin
			out_data_q <= {res_q[1][2], res_q[1][1], res_q[1][0],
				res_q[0][2], res_q[0][1], res_q[0][0]};
			out_user_q <= deg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_init |-> (ssum_q[61:58] != '0))
		else $error("sum of squares below normalised range");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |-> (sq_res_q[61:31] == '0) && (sq_res_q[30:29] != '0))
		else $error("root outside divisor range");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_wr |-> (q_q[0] <= 16'd32768) && (q_q[1] <= 16'd32768)
			&& (q_q[2] <= 16'd32768))
		else $error("quotient above unit range");

endmodule

// ----- rtl/triangle_normal_tangent_top.sv -----
// triangle_normal_tangent_top: per-triangle unit face normal and tangent
// depends on tnt_pkg, tnt_ctrl and tnt_dp
//
// channel   dir  transfer moves
// s_axis    in   one corner: position xyz Q16.16, texture uv Q4.16
// m_axis    out  one triangle: normal xyz, tangent xyz Q1.15, degenerate flags
//
// first and second corners of a triangle are taken while the sequencer is idle
// third corner: s_axis_tready stays low until the result is loaded, shortest with both vectors zero,
// longest through the one-bit normalising shifts, 31-step square root and 16-step divide
// per vector, all on one shared 34 x 34 multiplier
// arst_n clears the sequencer, corner count and output valid
// a finished result waits in the output register; corners are taken meanwhile
`timescale 1ns / 1ps

module triangle_normal_tangent_top
	import tnt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,  // normal_x/y/z, tangent_x/y/z
	output logic [DEG_W-1:0] m_axis_tuser   // degenerate
);

	cmd_t    cmd;
	status_t status;

	tnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tnt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

// ----- sim/tb_triangle_normal_tangent_top.sv -----
// tb_triangle_normal_tangent_top: self-checking bench for the triangle normal and tangent unit
// drives corners on s_axis, predicts each triangle result and checks every m_axis transfer
// depends on tnt_pkg and triangle_normal_tangent_top
`timescale 1ns / 1ps

module tb_triangle_normal_tangent_top;
	import tnt_pkg::*;

	localparam int          LIMIT      = 1000000;
	localparam int          QUIET_FROM = 10000;
	localparam int          QUIET_TO   = 30000;
	localparam int          RAND_ITEMS = 1150;
	localparam longint      HI30       = 64'sd1 << 30;
	localparam longint      LO29       = 64'sd1 << 29;
	localparam logic [1:0]  DEG_NONE   = 2'd0;
	localparam logic [1:0]  DEG_BOTH   = 2'd3;

	typedef longint vec_t [3];

	typedef struct {
		logic [15:0] f [7];
	} tri_res_t;

	typedef struct {
		int          px, py, pz;
		int          tu, tv;
		bit          typed;
		tri_res_t    res;
	} corner_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [DEG_W-1:0] m_axis_tuser;

	tri_res_t    expected_tris [$];
	corner_row_t corner_table [$];
	longint      held_pos [6];
	longint      held_uv [4];
	int          corners_held = 0;
	int          cycle = 0;
	int          errors = 0;
	int          tris_seen = 0;
	int          corners_sent = 0;
	int          degen_seen = 0;
	string       field_name [7] = '{"normal_x", "normal_y", "normal_z",
		"tangent_x", "tangent_y", "tangent_z", "degenerate"};

	triangle_normal_tangent_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic bit quiet_window();
		return cycle >= QUIET_FROM && cycle < QUIET_TO;
	endfunction

	function automatic bit take_break();
		return !quiet_window() && $urandom_range(0, 99) < 11;
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint signed_mag(longint unsigned m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// scale into [2^29, 2^30), then round m * 2^15 / |v| and saturate
	function automatic bit to_unit(vec_t v, output logic [15:0] o [3]);
		longint unsigned m [3];
		longint unsigned top = 0;
		longint unsigned sumsq, root, q;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag(v[i]);
			if (m[i] > top)
				top = m[i];
			o[i] = '0;
		end
		if (top == 0)
			return 1'b0;
		while (top >= HI30) begin
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
			top >>= 1;
		end
		while (top < LO29) begin
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
			top <<= 1;
		end
		sumsq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		root = int_sqrt(sumsq);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 32768 + root / 2) / root;
			if (q > 32767)
				q = 32767;
			o[i] = 16'(signed_mag(q, v[i] < 0));
		end
		return 1'b1;
	endfunction

	function automatic bit next_corner(logic [IN_W-1:0] d, output tri_res_t r);
		longint p [3];
		longint u, v, du1, dv1, du2, dv2, det;
		longint unsigned top = 0;
		vec_t e1, e2, s1, s2, nv, tv;
		logic [15:0] nu [3];
		logic [15:0] tu [3];
		int sh = 0;
		logic [1:0] deg = DEG_NONE;
		for (int i = 0; i < 3; i++)
			p[i] = longint'($signed(d[i*POS_W +: POS_W]));
		u = longint'($signed(d[3*POS_W +: TEX_W]));
		v = longint'($signed(d[3*POS_W+TEX_W +: TEX_W]));
		if (corners_held < 2) begin
			for (int i = 0; i < 3; i++)
				held_pos[corners_held*3 + i] = p[i];
			held_uv[corners_held*2] = u;
			held_uv[corners_held*2 + 1] = v;
			corners_held++;
			return 1'b0;
		end
		corners_held = 0;
		for (int i = 0; i < 3; i++) begin
			e1[i] = held_pos[3+i] - held_pos[i];
			e2[i] = p[i] - held_pos[i];
			if (mag(e1[i]) > top)
				top = mag(e1[i]);
			if (mag(e2[i]) > top)
				top = mag(e2[i]);
		end
		while ((top >> sh) >= HI30)
			sh++;
		for (int i = 0; i < 3; i++) begin
			s1[i] = signed_mag(mag(e1[i]) >> sh, e1[i] < 0);
			s2[i] = signed_mag(mag(e2[i]) >> sh, e2[i] < 0);
		end
		nv[0] = s1[1] * s2[2] - s1[2] * s2[1];
		nv[1] = s1[2] * s2[0] - s1[0] * s2[2];
		nv[2] = s1[0] * s2[1] - s1[1] * s2[0];
		du1 = held_uv[2] - held_uv[0];
		dv1 = held_uv[3] - held_uv[1];
		du2 = u - held_uv[0];
		dv2 = v - held_uv[1];
		det = du1 * dv2 - du2 * dv1;
		for (int i = 0; i < 3; i++) begin
			tv[i] = dv2 * e1[i] - dv1 * e2[i];
			if (det < 0)
				tv[i] = -tv[i];
		end
		if (!to_unit(nv, nu))
			deg[0] = 1'b1;
		if (!to_unit(tv, tu))
			deg[1] = 1'b1;
		for (int i = 0; i < 3; i++) begin
			r.f[i] = nu[i];
			r.f[3+i] = tu[i];
		end
		r.f[6] = 16'(deg);
		return 1'b1;
	endfunction

	function automatic logic [IN_W-1:0] pack_corner(corner_row_t c);
		return {c.tv[TEX_W-1:0], c.tu[TEX_W-1:0], c.pz, c.py, c.px};
	endfunction

	task automatic add_row(int px, int py, int pz, int tu, int tv, bit typed = 1'b0,
		logic [15:0] nx = 0, logic [15:0] ny = 0, logic [15:0] nz = 0,
		logic [15:0] tx = 0, logic [15:0] ty = 0, logic [15:0] tz = 0,
		logic [1:0] deg = DEG_NONE);
		corner_row_t c;
		c.px = px; c.py = py; c.pz = pz; c.tu = tu; c.tv = tv; c.typed = typed;
		c.res.f = '{nx, ny, nz, tx, ty, tz, 16'(deg)};
		corner_table = {corner_table, c};
	endtask

	task automatic send_corner(corner_row_t c);
		tri_res_t r;
		while (take_break()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_corner(c);
		do
			@(posedge clk);
		while (!s_axis_tready);
		corners_sent++;
		if (next_corner(pack_corner(c), r))
			expected_tris = {expected_tris, r};
		if (c.typed && corners_held == 0)
			expected_tris[$] = c.res;
	endtask

	function automatic int rand_coord(int mode);
		case (mode)
			0: return int'($urandom);
			1: return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
			default: return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
		endcase
	endfunction

	function automatic int rand_tex(int mode);
		if (mode == 0)
			return $signed(20'($urandom));
		return $signed($urandom_range(0, 16'hffff)) - 32'sh8000;
	endfunction

	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= !take_break();
	end

	always @(posedge clk) begin
		tri_res_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			for (int i = 0; i < 6; i++)
				got.f[i] = m_axis_tdata[i*RES_W +: RES_W];
			got.f[6] = 16'(m_axis_tuser);
			tris_seen++;
			if (m_axis_tuser != DEG_NONE)
				degen_seen++;
			if (expected_tris.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				want = expected_tris.pop_front();
				for (int i = 0; i < 7; i++)
					if (want.f[i] !== got.f[i]) begin
						$error("%s: expected %0h, got %0h", field_name[i], want.f[i], got.f[i]);
						errors++;
					end
			end
		end
	end

	initial begin
		corner_row_t c;
		int mode, tmode;
		// unit right triangle in xy, uv aligned with xy
		add_row(0, 0, 0, 0, 0);
		add_row(32'h10000, 0, 0, 32'h10000, 0);
		add_row(0, 32'h10000, 0, 0, 32'h10000, 1'b1,
			16'd0, 16'd0, 16'd32767, 16'd32767, 16'd0, 16'd0, DEG_NONE);
		// all corners coincide: both vectors zero
		add_row(0, 0, 0, 0, 0);
		add_row(0, 0, 0, 0, 0);
		add_row(0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0, 0, 0, DEG_BOTH);
		// collinear corners with flat uv
		add_row(32'h10000, 32'h10000, 32'h10000, 5, 5);
		add_row(32'h20000, 32'h20000, 32'h20000, 5, 5);
		add_row(32'h30000, 32'h30000, 32'h30000, 5, 5, 1'b1,
			0, 0, 0, 0, 0, 0, DEG_BOTH);
		// negative uv determinant flips the tangent
		add_row(0, 0, 0, 0, 0);
		add_row(32'h10000, 0, 0, 0, 32'h10000);
		add_row(0, 32'h10000, 0, 32'h10000, 0);
		// zero determinant, tangent non-zero
		add_row(0, 0, 0, 0, 0);
		add_row(32'h10000, 0, 0, 32'h100, 32'h100);
		add_row(0, 0, 32'h10000, 32'h200, 32'h200);
		// field extremes: edges need scaling before the cross product
		add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'hfff80000, 32'hfff80000);
		add_row(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h0007ffff, 32'hfff80000);
		add_row(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'hfff80000, 32'h0007ffff);
		add_row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h0007ffff, 32'h0007ffff);
		add_row(32'h80000000, 32'h80000000, 32'h7fffffff, 0, 32'h0007ffff);
		add_row(-1, 1, -1, -1, 1);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corner_table[i])
			send_corner(corner_table[i]);
		for (int n = 0; n < RAND_ITEMS; n++) begin
			mode = $urandom_range(0, 2);
			tmode = $urandom_range(0, 1);
			c.typed = 1'b0;
			if ($urandom_range(0, 19) == 0 && corners_held > 0) begin
				c.px = int'(held_pos[0]); c.py = int'(held_pos[1]); c.pz = int'(held_pos[2]);
			end else begin
				c.px = rand_coord(mode); c.py = rand_coord(mode); c.pz = rand_coord(mode);
			end
			c.tu = rand_tex(tmode);
			c.tv = rand_tex(tmode);
			send_corner(c);
		end
		s_axis_tvalid <= 1'b0;
		while (expected_tris.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		$display("corners sent: %0d, triangles checked: %0d, with degenerate flags: %0d",
			corners_sent, tris_seen, degen_seen);
		$display("covered full-range, small and repeated corners with random stalls");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
